// ===== hw/rtl/plrs_pkg.sv =====
// Package for the piecewise-linear sampler: operation and status codes, widths.
// No dependencies.
package plrs_pkg;

  localparam int unsigned MaxPointsDefault = 256;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_DESCEND = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] point_x;
    logic [15:0] point_density;
    logic [15:0] uniform_segment;
    logic [15:0] uniform_part;
    logic [15:0] uniform_position;
  } req_t;

  typedef struct packed {
    logic [31:0] sample_value;
    logic [1:0]  status;
  } res_t;

endpackage

// ===== hw/rtl/plrs_if.sv =====
// Valid/ready channel interfaces, each carrying one payload type.
// Depends on plrs_pkg for payload types.
interface plrs_req_if;
  logic               valid;
  logic               ready;
  plrs_pkg::req_t     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface plrs_res_if;
  logic               valid;
  logic               ready;
  plrs_pkg::res_t     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/piecewise_linear_random_sampler_top.sv =====
// Channel      Dir  Payload
// in_if        in   operation, point_x, point_density, uniform_*
// out_if       out  sample_value, status
// A load into an empty table writes at once; otherwise it reads the last point, multiplies, then writes.
// A sample reads the total area, forms the target, runs the binary search (each step passes S_SRCH,
// S_SRCHRD and S_PART), fetches both segment ends, then runs the one-digit-a-cycle square root.
// The back end takes a new item only once its result has been accepted.
// Reset empties the table; the two-entry queue accepts up to two items while the back stalls.
// Top level of the piecewise-linear sampler; depends on plrs_pkg, plrs_if,
// plrs_front and plrs_back.
module piecewise_linear_random_sampler_top #(
  parameter int unsigned MaxPoints = plrs_pkg::MaxPointsDefault
) (
  input logic       clk_i,
  input logic       rst_ni,
  plrs_req_if.sink  in_if,
  plrs_res_if.source out_if
);
  logic q_valid, q_ready;
  plrs_pkg::req_t q_data;

  plrs_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .in_data_i(in_if.data),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_data_o(q_data)
  );

  plrs_back #(.MaxPoints(MaxPoints)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_data_i(q_data),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .out_data_o(out_if.data)
  );
endmodule

// ===== hw/rtl/plrs_front.sv =====
// Front end: accepts items and holds them in a two-entry queue for the back end.
// Depends on plrs_pkg.
module plrs_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  plrs_pkg::req_t in_data_i,
  output logic           q_valid_o,
  input  logic           q_ready_i,
  output plrs_pkg::req_t q_data_o
);
  plrs_pkg::req_t mem_q [2];
  logic rd_q, wr_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_data_o   = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0;
      wr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_data_i;
  end
endmodule

// ===== hw/rtl/plrs_back.sv =====
// Back end: point tables, binary search, bit-serial square root, output register.
// Depends on plrs_pkg.
module plrs_back #(
  parameter int unsigned MaxPoints = plrs_pkg::MaxPointsDefault,
  localparam int unsigned AW = $clog2(MaxPoints),
  localparam int unsigned CW = $clog2(MaxPoints + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  output logic           q_ready_o,
  input  plrs_pkg::req_t q_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output plrs_pkg::res_t out_data_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_LDRD, S_LDMUL, S_LDWR, S_TOT, S_TGT1, S_TGT2, S_SRCH, S_SRCHRD,
    S_FETCH0, S_FETCH1, S_PART, S_SQRT, S_MUL, S_DONE
  } state_e;

  state_e state_q;
  plrs_pkg::req_t req_q;
  logic [CW-1:0] cnt_q;
  logic [31:0] pos_mem [MaxPoints];
  logic [15:0] den_mem [MaxPoints];
  logic [63:0] cdf_mem [MaxPoints];
  logic [31:0] pos_rd_q;
  logic [15:0] den_rd_q;
  logic [63:0] cdf_rd_q;
  logic [AW-1:0] raddr;
  logic        we;
  logic [AW-1:0] waddr;
  logic [63:0] wcdf;
  logic [63:0] acc_q, tgt_q;
  logic [AW-1:0] lo_q, hi_q, mid_q;
  logic [31:0] x0_q, x1_q, sqv_q, res_q, bit_q;
  logic [15:0] p0_q, p1_q;
  logic        tri_q, rise_q;
  logic [48:0] prod_q;
  logic        ovalid_q;
  plrs_pkg::res_t odata_q;
  logic [31:0] dx;
  logic [31:0] ld_dx;
  logic [16:0] psum;
  logic [15:0] pdiff;
  logic [31:0] sq_sum;
  logic [47:0] off_full;
  logic [31:0] off;

  assign q_ready_o   = (state_q == S_IDLE) && !ovalid_q;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;
  assign dx    = x1_q - x0_q;
  assign ld_dx = req_q.point_x - pos_rd_q;
  assign psum  = {1'b0, p0_q} + {1'b0, p1_q};
  assign pdiff = (p1_q > p0_q) ? (p1_q - p0_q) : (p0_q - p1_q);
  assign sq_sum = res_q + bit_q;
  // Offset inside the segment: the square root in the triangle part, else the uniform.
  assign off_full = (tri_q ? 48'(res_q[15:0]) : 48'(req_q.uniform_position)) * 48'(dx);
  assign off = off_full[47:16];

  always_comb begin
    raddr = mid_q;
    we = (state_q == S_LDWR);
    waddr = cnt_q[AW-1:0];
    wcdf = (cnt_q == '0) ? 64'd0 : cdf_rd_q + {15'd0, prod_q};
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      pos_mem[waddr] <= req_q.point_x;
      den_mem[waddr] <= req_q.point_density;
      cdf_mem[waddr] <= wcdf;
    end
    pos_rd_q <= pos_mem[raddr];
    den_rd_q <= den_mem[raddr];
    cdf_rd_q <= cdf_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i && !ovalid_q) begin
            req_q <= q_data_i;
            unique case (q_data_i.operation)
              plrs_pkg::OP_LOAD: begin
                if ({1'b0, cnt_q} >= (CW+1)'(MaxPoints)) begin
                  odata_q <= '{32'd0, plrs_pkg::ST_FULL};
                  ovalid_q <= 1'b1;
                end else begin
                  mid_q <= AW'(cnt_q - 1'b1);
                  state_q <= (cnt_q == '0) ? S_LDWR : S_LDRD;
                end
              end
              plrs_pkg::OP_CLEAR: begin
                cnt_q <= '0;
                odata_q <= '{32'd0, plrs_pkg::ST_OK};
                ovalid_q <= 1'b1;
              end
              plrs_pkg::OP_SAMPLE: begin
                if (cnt_q < CW'(2)) begin
                  odata_q <= '{32'd0, plrs_pkg::ST_EMPTY};
                  ovalid_q <= 1'b1;
                end else begin
                  mid_q <= AW'(cnt_q - 1'b1);
                  state_q <= S_LDRD;
                end
              end
              default: begin
                odata_q <= '{32'd0, plrs_pkg::ST_OK};
                ovalid_q <= 1'b1;
              end
            endcase
          end
        end
        S_LDRD: state_q <= (req_q.operation == plrs_pkg::OP_LOAD) ? S_LDMUL : S_TOT;
        S_LDMUL: begin
          if ($signed(req_q.point_x) < $signed(pos_rd_q)) begin
            odata_q <= '{32'd0, plrs_pkg::ST_DESCEND};
            ovalid_q <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            prod_q <= 49'({1'b0, den_rd_q} + {1'b0, req_q.point_density}) * 49'(ld_dx);
            state_q <= S_LDWR;
          end
        end
        S_LDWR: begin
          cnt_q <= cnt_q + 1'b1;
          odata_q <= '{32'd0, plrs_pkg::ST_OK};
          ovalid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        S_TOT: begin
          if (cdf_rd_q == 64'd0) begin
            odata_q <= '{32'd0, plrs_pkg::ST_EMPTY};
            ovalid_q <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            acc_q <= cdf_rd_q;
            prod_q <= 49'(cdf_rd_q[47:16]) * 49'(req_q.uniform_segment);
            state_q <= S_TGT1;
          end
        end
        S_TGT1: begin
          tgt_q <= {15'd0, prod_q};
          prod_q <= 49'(acc_q[15:0]) * 49'(req_q.uniform_segment);
          state_q <= S_TGT2;
        end
        S_TGT2: begin
          tgt_q <= tgt_q + {31'd0, prod_q[48:16]}
                   + {32'(acc_q[63:48]) * 32'(req_q.uniform_segment), 32'd0};
          lo_q <= '0;
          hi_q <= AW'(cnt_q - 2'd2);
          state_q <= S_SRCH;
        end
        S_SRCH: begin
          if (lo_q >= hi_q) begin
            mid_q <= lo_q;
            state_q <= S_FETCH0;
          end else begin
            mid_q <= AW'(({1'b0, lo_q} + {1'b0, hi_q} + 1'b1) >> 1);
            state_q <= S_SRCHRD;
          end
        end
        S_SRCHRD: state_q <= S_PART;
        S_FETCH0: begin
          mid_q <= lo_q + 1'b1;
          state_q <= S_FETCH1;
        end
        S_FETCH1: begin
          x0_q <= pos_rd_q;
          p0_q <= den_rd_q;
          state_q <= S_MUL;
        end
        S_PART: begin
          // A search read returned: narrow the search range.
          if (cdf_rd_q <= tgt_q) lo_q <= mid_q;
          else hi_q <= mid_q - 1'b1;
          state_q <= S_SRCH;
        end
        S_MUL: begin
          x1_q <= pos_rd_q;
          p1_q <= den_rd_q;
          res_q <= '0;
          bit_q <= 32'h4000_0000;
          sqv_q <= {req_q.uniform_position, 16'd0};
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          // One digit of the square root per cycle.
          if (bit_q == '0) begin
            tri_q <= (pdiff != '0) &&
                     ((33'(req_q.uniform_part) * 33'(psum)) <= {1'b0, pdiff, 16'd0});
            rise_q <= p0_q < p1_q;
            state_q <= S_DONE;
          end else begin
            if (sqv_q >= sq_sum) begin
              sqv_q <= sqv_q - sq_sum;
              res_q <= (res_q >> 1) + bit_q;
            end else begin
              res_q <= res_q >> 1;
            end
            bit_q <= bit_q >> 2;
          end
        end
        S_DONE: begin
          state_q <= S_IDLE;
          odata_q <= '{(tri_q && !rise_q) ? x1_q - off : x0_q + off, plrs_pkg::ST_OK};
          ovalid_q <= 1'b1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/plrs_checker.sv =====
// Port-level checker for the sampler top level, bound in below.
// Depends on plrs_pkg.
module plrs_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input plrs_pkg::res_t out_data_i
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i)) else $error("hold");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status != plrs_pkg::ST_OK |-> out_data_i.sample_value == '0)
    else $error("error with value");
  a_reset: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i) else $error("rst");
endmodule

bind piecewise_linear_random_sampler_top plrs_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid_i(out_if.valid),
  .out_ready_i(out_if.ready), .out_data_i(out_if.data)
);

// ===== sim/plrs_tb_if.sv =====
// Testbench copies of the valid/ready channel interfaces are not needed; the RTL
// interfaces are reused. This file holds the stimulus/result record helpers.
// Depends on plrs_pkg.
`timescale 1ns / 100ps
package plrs_tb_pkg;

  typedef struct {
    plrs_pkg::op_e     op;
    logic [31:0]       x;
    logic [15:0]       dens;
    logic [15:0]       u_seg;
    logic [15:0]       u_part;
    logic [15:0]       u_pos;
    bit                fixed;
    logic [31:0]       want_value;
    plrs_pkg::status_e want_status;
  } stim_row_t;
endpackage

// ===== sim/piecewise_linear_random_sampler_top_tb.sv =====
// Self-checking bench for the piecewise-linear sampler: a directed table, a full-table
// fill, then random traffic of all operations, checked against a behavioral predictor.
// Depends on plrs_pkg, plrs_if, plrs_tb_pkg and the sampler RTL.
`timescale 1ns / 100ps
module piecewise_linear_random_sampler_top_tb;

  localparam int unsigned Points = 256;
  localparam int unsigned StallLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  plrs_req_if in_if ();
  plrs_res_if out_if ();

  piecewise_linear_random_sampler_top #(.MaxPoints(Points)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if), .out_if(out_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state.
  logic [31:0] pos_tab [Points];
  logic [15:0] dens_tab [Points];
  logic [63:0] area_tab [Points];
  int unsigned pt_count;

  plrs_pkg::res_t expected_q [$];
  int unsigned errors;
  int unsigned idle_cycles;

  function automatic logic [31:0] int_sqrt(logic [31:0] v);
    logic [31:0] r;
    logic [31:0] b;
    r = 0;
    b = 32'h4000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Computes the answer to one item and updates the point table.
  function automatic plrs_pkg::res_t predict_sample(plrs_pkg::op_e op, logic [31:0] x,
                                                    logic [15:0] p, logic [15:0] u1,
                                                    logic [15:0] u2, logic [15:0] u3);
    plrs_pkg::res_t r;
    logic [63:0] total, target, dx, lhs, rhs, off;
    logic [31:0] x0, x1, s;
    logic [16:0] p0, p1, diff;
    int unsigned lo, hi, mid;
    r.sample_value = '0;
    r.status = plrs_pkg::ST_OK;
    case (op)
      plrs_pkg::OP_LOAD: begin
        if (pt_count >= Points) begin
          r.status = plrs_pkg::ST_FULL;
        end else if (pt_count > 0 && $signed(x) < $signed(pos_tab[pt_count-1])) begin
          r.status = plrs_pkg::ST_DESCEND;
        end else begin
          if (pt_count == 0) area_tab[0] = 0;
          else begin
            dx = {32'd0, x - pos_tab[pt_count-1]};
            area_tab[pt_count] = area_tab[pt_count-1]
                                 + ({48'd0, dens_tab[pt_count-1]} + p) * dx;
          end
          pos_tab[pt_count] = x;
          dens_tab[pt_count] = p;
          pt_count++;
        end
      end
      plrs_pkg::OP_CLEAR: pt_count = 0;
      plrs_pkg::OP_SAMPLE: begin
        if (pt_count < 2 || area_tab[pt_count-1] == 0) begin
          r.status = plrs_pkg::ST_EMPTY;
        end else begin
          total = area_tab[pt_count-1];
          target = (total >> 16) * u1 + (((total & 64'hFFFF) * u1) >> 16);
          lo = 0;
          hi = pt_count - 2;
          while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (area_tab[mid] <= target) lo = mid;
            else hi = mid - 1;
          end
          x0 = pos_tab[lo];
          x1 = pos_tab[lo+1];
          dx = {32'd0, x1 - x0};
          p0 = dens_tab[lo];
          p1 = dens_tab[lo+1];
          diff = (p1 > p0) ? p1 - p0 : p0 - p1;
          lhs = {48'd0, u2} * (p0 + p1);
          rhs = {47'd0, diff} << 16;
          if (diff != 0 && lhs <= rhs) begin
            s = int_sqrt({u3, 16'd0});
            off = ({32'd0, s} * dx) >> 16;
            r.sample_value = (p0 < p1) ? x0 + off[31:0] : x1 - off[31:0];
          end else begin
            off = ({48'd0, u3} * dx) >> 16;
            r.sample_value = x0 + off[31:0];
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Sends one item with burst/gap pacing and queues its expected result.
  int unsigned burst_left;

  task automatic send_item(plrs_pkg::op_e op, logic [31:0] x, logic [15:0] p,
                           logic [15:0] u1, logic [15:0] u2, logic [15:0] u3, bit fixed,
                           logic [31:0] wv, plrs_pkg::status_e ws);
    plrs_pkg::res_t r;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 60) : $urandom_range(0, 3);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.data <= '{operation: op, point_x: x, point_density: p,
                    uniform_segment: u1, uniform_part: u2, uniform_position: u3};
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    r = predict_sample(op, x, p, u1, u2, u3);
    if (fixed && (r.sample_value !== wv || r.status !== ws))
      report_mismatch("predictor vs table", {r.sample_value[29:0], r.status}, {wv[29:0], ws});
    expected_q.push_back(r);
  endtask

  task automatic drain_all;
    if (in_if.valid) in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    plrs_pkg::res_t want;
    if (out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", out_if.data.sample_value, 32'd0);
      end else begin
        want = expected_q.pop_front();
        if (out_if.data.sample_value !== want.sample_value)
          report_mismatch("sample_value", out_if.data.sample_value, want.sample_value);
        if (out_if.data.status !== want.status)
          report_mismatch("status", {30'd0, out_if.data.status}, {30'd0, want.status});
      end
    end
  end

  // Receiver stalls: stretches of full readiness alternate with choppy ones.
  initial begin
    int unsigned phase_len;
    bit choppy;
    out_if.ready = 1'b0;
    forever begin
      choppy = $urandom_range(0, 1);
      phase_len = $urandom_range(10, 200);
      repeat (phase_len) begin
        @(posedge clk_i);
        out_if.ready <= choppy ? ($urandom_range(0, 2) != 0) : 1'b1;
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  plrs_tb_pkg::stim_row_t directed [$];

  function automatic plrs_tb_pkg::stim_row_t row(plrs_pkg::op_e op, logic [31:0] x,
                                                 logic [15:0] p, logic [15:0] u1,
                                                 logic [15:0] u2, logic [15:0] u3,
                                                 bit fixed, logic [31:0] wv,
                                                 plrs_pkg::status_e ws);
    plrs_tb_pkg::stim_row_t s;
    s = '{op, x, p, u1, u2, u3, fixed, wv, ws};
    return s;
  endfunction

  // Clears, loads n random points (mostly ascending, some descending), then sends draws items, mostly samples.
  task automatic random_table(int unsigned n, int unsigned draws);
    logic [31:0] x;
    logic [15:0] p;
    x = $urandom_range(0, 1) ? $urandom : -$urandom_range(0, 1 << 24);
    send_item(plrs_pkg::OP_CLEAR, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 0, 0, plrs_pkg::ST_OK);
    for (int unsigned k = 0; k < n; k++) begin
      p = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom);
      if ($urandom_range(0, 15) == 0) x = x - $urandom_range(1, 1000);
      else if (k > 0) x = x + (($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 1 << 20));
      send_item(plrs_pkg::OP_LOAD, x, p, 16'($urandom), 16'($urandom), 16'($urandom),
                0, 0, plrs_pkg::ST_OK);
    end
    repeat (draws)
      send_item(plrs_pkg::op_e'($urandom_range(0, 9) == 0 ? $urandom_range(0, 3)
                                                          : plrs_pkg::OP_SAMPLE),
                $urandom, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                0, 0, plrs_pkg::ST_OK);
  endtask

  initial begin
    int unsigned sent;
    in_if.valid = 1'b0;
    in_if.data = '0;
    pt_count = 0;
    errors = 0;
    idle_cycles = 0;
    burst_left = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed.push_back(row(plrs_pkg::OP_SAMPLE, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0,
                           plrs_pkg::ST_EMPTY));
    directed.push_back(row(plrs_pkg::OP_NONE, 32'hFFFF_FFFF, 16'hFFFF, 0, 0, 0, 1, 0,
                           plrs_pkg::ST_OK));
    directed.push_back(row(plrs_pkg::OP_LOAD, 32'h8000_0000, 16'hFFFF, 0, 0, 0, 1, 0,
                           plrs_pkg::ST_OK));
    directed.push_back(row(plrs_pkg::OP_SAMPLE, 0, 0, 0, 0, 0, 1, 0, plrs_pkg::ST_EMPTY));
    directed.push_back(row(plrs_pkg::OP_LOAD, 32'h8000_0000, 16'd0, 0, 0, 0, 1, 0,
                           plrs_pkg::ST_OK));
    directed.push_back(row(plrs_pkg::OP_LOAD, 32'h7FFF_FFFF, 16'd0, 0, 0, 0, 1, 0,
                           plrs_pkg::ST_OK));
    directed.push_back(row(plrs_pkg::OP_SAMPLE, 0, 0, 0, 0, 16'hFFFF, 0, 0, plrs_pkg::ST_OK));
    directed.push_back(row(plrs_pkg::OP_SAMPLE, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0,
                           plrs_pkg::ST_OK));
    // Every segment so far has zero area.
    directed.push_back(row(plrs_pkg::OP_SAMPLE, 0, 0, 0, 0, 0, 1, 0, plrs_pkg::ST_EMPTY));
    directed.push_back(row(plrs_pkg::OP_LOAD, 32'h7FFF_FFFE, 16'h1234, 0, 0, 0, 1, 0,
                           plrs_pkg::ST_DESCEND));
    directed.push_back(row(plrs_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 1, 0, plrs_pkg::ST_OK));
    directed.push_back(row(plrs_pkg::OP_LOAD, 32'h0001_0000, 0, 0, 0, 0, 1, 0,
                           plrs_pkg::ST_OK));
    directed.push_back(row(plrs_pkg::OP_LOAD, 32'h0002_0000, 0, 0, 0, 0, 1, 0,
                           plrs_pkg::ST_OK));
    // Zero total area.
    directed.push_back(row(plrs_pkg::OP_SAMPLE, 0, 0, 16'h8000, 0, 0, 1, 0,
                           plrs_pkg::ST_EMPTY));
    directed.push_back(row(plrs_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 1, 0, plrs_pkg::ST_OK));
    directed.push_back(row(plrs_pkg::OP_LOAD, 32'h0000_0000, 16'h0000, 0, 0, 0, 1, 0,
                           plrs_pkg::ST_OK));
    directed.push_back(row(plrs_pkg::OP_LOAD, 32'h0001_0000, 16'hFFFF, 0, 0, 0, 1, 0,
                           plrs_pkg::ST_OK));
    directed.push_back(row(plrs_pkg::OP_LOAD, 32'h0002_0000, 16'h0000, 0, 0, 0, 1, 0,
                           plrs_pkg::ST_OK));
    // Rising and falling triangle parts, then flat rectangle via a repeated position.
    directed.push_back(row(plrs_pkg::OP_SAMPLE, 0, 0, 16'h1000, 0, 16'h4000, 0, 0,
                           plrs_pkg::ST_OK));
    directed.push_back(row(plrs_pkg::OP_SAMPLE, 0, 0, 16'hF000, 0, 16'h4000, 0, 0,
                           plrs_pkg::ST_OK));
    directed.push_back(row(plrs_pkg::OP_LOAD, 32'h0002_0000, 16'h8000, 0, 0, 0, 1, 0,
                           plrs_pkg::ST_OK));
    directed.push_back(row(plrs_pkg::OP_LOAD, 32'h0003_0000, 16'h8000, 0, 0, 0, 1, 0,
                           plrs_pkg::ST_OK));
    directed.push_back(row(plrs_pkg::OP_SAMPLE, 0, 0, 16'hFFFF, 16'hFFFF, 16'h8000, 0, 0,
                           plrs_pkg::ST_OK));

    foreach (directed[k])
      send_item(directed[k].op, directed[k].x, directed[k].dens, directed[k].u_seg,
                directed[k].u_part, directed[k].u_pos, directed[k].fixed,
                directed[k].want_value, directed[k].want_status);

    // Fill the table to its limit, then try one more load.
    drain_all();
    send_item(plrs_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 1, 0, plrs_pkg::ST_OK);
    for (int unsigned k = 0; k < Points; k++)
      send_item(plrs_pkg::OP_LOAD, k << 12, 16'($urandom), 0, 0, 0, 1, 0, plrs_pkg::ST_OK);
    send_item(plrs_pkg::OP_LOAD, 32'h7FFF_FFFF, 0, 0, 0, 0, 1, 0, plrs_pkg::ST_FULL);
    for (int unsigned k = 0; k < 20; k++)
      send_item(plrs_pkg::OP_SAMPLE, 0, 0, 16'($urandom), 16'($urandom), 16'($urandom),
                0, 0, plrs_pkg::ST_OK);

    sent = 0;
    while (sent < 250) begin
      int unsigned n;
      int unsigned d;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 8);
      d = $urandom_range(4, 20);
      random_table(n, d);
      sent += n + d + 1;
      if ($urandom_range(0, 7) == 0) drain_all();
    end

    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
